FILE: rtl/download_throughput_estimator_unit_assert.svh
// assertion macros for the download throughput estimator
// used by the top level only, no other dependencies
`ifndef DOWNLOAD_THROUGHPUT_ESTIMATOR_UNIT_ASSERT_SVH
`define DOWNLOAD_THROUGHPUT_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dte assertion failed");

// next-cycle implication, checked out of reset
`define DTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dte assertion failed");

`endif

FILE: rtl/dte_pkg.sv
// shared types, constants and helpers of the download throughput estimator
// no dependencies
package dte_pkg;

    localparam int HIST_DEPTH = 24;
    localparam int HIST_IW    = $clog2(HIST_DEPTH);
    localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
    localparam int WIN_W      = 5;
    localparam int KCMP_W     = (HIST_CW > WIN_W) ? HIST_CW : WIN_W;

    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [19:0] US_PER_S   = 20'd1000000;
    localparam logic [39:0] MAX40      = 40'hFF_FFFF_FFFF;
    localparam int          RECIP_SHIFT = 56;

    localparam logic        CMD_RECORD  = 1'b0;
    localparam logic        CMD_PREDICT = 1'b1;

    localparam logic [1:0]  CFG_ALPHA_FAST = 2'd0;
    localparam logic [1:0]  CFG_ALPHA_SLOW = 2'd1;
    localparam logic [1:0]  CFG_HWINDOW    = 2'd2;
    localparam logic [1:0]  CFG_HBLEND     = 2'd3;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [16:0] sat_q16(input logic [16:0] w);
        return (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

    function automatic logic [39:0] sat40(input logic [63:0] v);
        return (v > {24'd0, MAX40}) ? MAX40 : v[39:0];
    endfunction

endpackage

FILE: rtl/dte_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on dte_pkg
module dte_div import dte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]     r_q;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W:0]       w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_cnt  <= DIV_CNT_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fit ? DIV_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

FILE: rtl/download_throughput_estimator_unit.sv
// download throughput estimator: one item at a time under a sequencer, shared divider
// one item in flight at a time; input is ready only while the sequencer is idle
// reset: synchronous active low, clears sequencer, averages, history count and registers
// depends on dte_pkg, dte_div and the assertion macro header
`include "download_throughput_estimator_unit_assert.svh"
module download_throughput_estimator_unit import dte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_total_time_us,
    input  logic [31:0] i_first_byte_time_us,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [39:0] o_throughput_bps,
    output logic [31:0] o_first_byte_estimate_us,
    output logic [39:0] o_predicted_time_us,
    output logic [31:0] o_echoed_total_us
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_RMUL     = 5'd1;
    localparam logic [4:0] ST_RDIV     = 5'd2;
    localparam logic [4:0] ST_RWAIT    = 5'd3;
    localparam logic [4:0] ST_FAST     = 5'd4;
    localparam logic [4:0] ST_FAST_UPD = 5'd5;
    localparam logic [4:0] ST_SLOW     = 5'd6;
    localparam logic [4:0] ST_SLOW_UPD = 5'd7;
    localparam logic [4:0] ST_MRD      = 5'd8;
    localparam logic [4:0] ST_MCAP     = 5'd9;
    localparam logic [4:0] ST_MSW      = 5'd10;
    localparam logic [4:0] ST_MEVAL    = 5'd11;
    localparam logic [4:0] ST_MFIN     = 5'd12;
    localparam logic [4:0] ST_HINIT    = 5'd13;
    localparam logic [4:0] ST_HRD      = 5'd14;
    localparam logic [4:0] ST_HCHK     = 5'd15;
    localparam logic [4:0] ST_HWAIT    = 5'd16;
    localparam logic [4:0] ST_HNEXT    = 5'd17;
    localparam logic [4:0] ST_HFIN     = 5'd18;
    localparam logic [4:0] ST_HFWAIT   = 5'd19;
    localparam logic [4:0] ST_EST      = 5'd20;
    localparam logic [4:0] ST_EST_UPD  = 5'd21;
    localparam logic [4:0] ST_POST     = 5'd22;
    localparam logic [4:0] ST_PMUL     = 5'd23;
    localparam logic [4:0] ST_PDIV     = 5'd24;
    localparam logic [4:0] ST_PWAIT    = 5'd25;
    localparam logic [4:0] ST_DONE     = 5'd26;
    localparam logic [4:0] ST_B1       = 5'd27;
    localparam logic [4:0] ST_B2       = 5'd28;
    localparam logic [4:0] ST_B3       = 5'd29;

    logic [4:0]          r_state;
    logic [4:0]          r_ret;
    logic                r_cmd;
    logic [31:0]         r_size;
    logic [31:0]         r_total;
    logic [31:0]         r_ttfb;
    logic [16:0]         r_af;
    logic [16:0]         r_as;
    logic [WIN_W-1:0]    r_hw;
    logic [16:0]         r_hb;
    logic [HIST_IW-1:0]  r_head;
    logic [HIST_CW-1:0]  r_count;
    logic [39:0]         r_fast;
    logic [39:0]         r_slow;
    logic [39:0]         r_harm;
    logic [31:0]         r_med;
    logic [39:0]         r_rate;
    logic [59:0]         r_mul;
    logic [59:0]         r_acc;
    logic [16:0]         r_bw;
    logic [39:0]         r_bx;
    logic [39:0]         r_by;
    logic [39:0]         r_bres;
    logic [HIST_CW-1:0]  r_ci;
    logic [HIST_IW-1:0]  r_j;
    logic [HIST_CW-1:0]  r_lt;
    logic [HIST_CW-1:0]  r_le;
    logic [31:0]         r_cand;
    logic [31:0]         r_mlo;
    logic [31:0]         r_mhi;
    logic [HIST_CW-1:0]  r_hi;
    logic [HIST_IW-1:0]  r_p;
    logic [63:0]         r_sum;
    logic [HIST_CW-1:0]  r_kept;
    logic [39:0]         r_thr;
    logic [39:0]         r_pred;
    logic                r_ovalid;
    logic [39:0]         r_o_thr;
    logic [31:0]         r_o_med;
    logic [39:0]         r_o_pred;
    logic [31:0]         r_o_echo;
    logic [31:0]         r_fb_mem [HIST_DEPTH];
    logic [39:0]         r_rt_mem [HIST_DEPTH];
    logic [31:0]         r_fb_rd;
    logic [39:0]         r_rt_rd;

    logic [19:0]         w_mul_a;
    logic [39:0]         w_mul_b;
    logic [HIST_IW-1:0]  w_fb_raddr;
    logic [HIST_CW-1:0]  w_j_next;
    logic [31:0]         w_pay;
    logic [HIST_CW-1:0]  w_k;
    logic [39:0]         w_m;
    logic [39:0]         w_rate_sat;
    logic [HIST_CW-1:0]  w_phi;
    logic [HIST_CW-1:0]  w_plo;
    logic                w_load;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    dte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_pay      = (r_total > r_ttfb) ? (r_total - r_ttfb) : 32'd1;
    assign w_k        = (KCMP_W'(r_hw) < KCMP_W'(r_count)) ? HIST_CW'(r_hw) : r_count;
    assign w_rate_sat = sat40(w_div_rsp.quotient);
    assign w_phi      = r_count >> 1;
    assign w_plo      = w_phi - 1'b1;
    assign w_j_next   = HIST_CW'(r_j) + 1'b1;
    assign w_load     = (r_state == ST_DONE) && (!r_ovalid || i_out_ready);

    // lower of the two averages once both are seeded, else whichever is nonzero
    always_comb begin
        if (r_fast != '0 && r_slow != '0) begin
            w_m = (r_fast < r_slow) ? r_fast : r_slow;
        end else begin
            w_m = (r_fast > r_slow) ? r_fast : r_slow;
        end
    end

    always_comb begin
        case (r_state)
            ST_RMUL, ST_PMUL: begin
                w_mul_a = US_PER_S;
                w_mul_b = {8'd0, r_size};
            end
            ST_B1: begin
                w_mul_a = {3'd0, r_bw};
                w_mul_b = r_bx;
            end
            ST_B2: begin
                w_mul_a = {3'd0, ONE_Q16 - r_bw};
                w_mul_b = r_by;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // first-byte read address: candidate fetch, then a sweep over the filled slots
    always_comb begin
        case (r_state)
            ST_MRD:  w_fb_raddr = r_ci[HIST_IW-1:0];
            ST_MSW:  w_fb_raddr = (w_j_next == r_count) ? '0 : w_j_next[HIST_IW-1:0];
            default: w_fb_raddr = '0;
        endcase
    end

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = 64'd1;
        case (r_state)
            ST_RDIV: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {4'd0, r_mul};
                w_div_req.divisor  = {32'd0, w_pay};
            end
            ST_HCHK: begin
                w_div_req.start    = (r_rt_rd != '0);
                w_div_req.dividend = 64'd1 << RECIP_SHIFT;
                w_div_req.divisor  = {24'd0, r_rt_rd};
            end
            ST_HFIN: begin
                w_div_req.start    = (r_kept != '0);
                w_div_req.dividend = 64'(r_kept) << RECIP_SHIFT;
                w_div_req.divisor  = r_sum;
            end
            ST_PDIV: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = {4'd0, r_mul} + {25'd0, r_thr[39:1]};
                w_div_req.divisor  = {24'd0, r_thr};
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul <= {40'd0, w_mul_a} * {20'd0, w_mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RWAIT && w_div_rsp.done) begin
            r_fb_mem[r_head] <= r_ttfb;
            r_rt_mem[r_head] <= w_rate_sat;
        end
        r_fb_rd <= r_fb_mem[w_fb_raddr];
        r_rt_rd <= r_rt_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_af     <= 17'd32768;
            r_as     <= 17'd6554;
            r_hw     <= 5'd8;
            r_hb     <= 17'd39322;
            r_head   <= '0;
            r_count  <= '0;
            r_fast   <= '0;
            r_slow   <= '0;
            r_harm   <= '0;
            r_med    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_ALPHA_FAST: r_af <= i_cfg_wdata;
                    CFG_ALPHA_SLOW: r_as <= i_cfg_wdata;
                    CFG_HWINDOW:    r_hw <= i_cfg_wdata[WIN_W-1:0];
                    CFG_HBLEND:     r_hb <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_ovalid && i_out_ready && !w_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_command;
                        r_size  <= i_size_bytes;
                        r_total <= i_total_time_us;
                        r_ttfb  <= i_first_byte_time_us;
                        r_pred  <= '0;
                        r_state <= (i_command == CMD_RECORD) ? ST_RMUL : ST_EST;
                    end
                end
                ST_RMUL: r_state <= ST_RDIV;
                ST_RDIV: r_state <= ST_RWAIT;
                ST_RWAIT: begin
                    if (w_div_rsp.done) begin
                        r_rate  <= w_rate_sat;
                        r_head  <= (r_head == HIST_IW'(HIST_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        if (r_count < HIST_CW'(HIST_DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_ci    <= '0;
                        r_state <= ST_FAST;
                    end
                end
                ST_FAST: begin
                    if (r_fast == '0) begin
                        r_fast  <= r_rate;
                        r_state <= ST_SLOW;
                    end else begin
                        r_bw    <= sat_q16(r_af);
                        r_bx    <= r_rate;
                        r_by    <= r_fast;
                        r_ret   <= ST_FAST_UPD;
                        r_state <= ST_B1;
                    end
                end
                ST_FAST_UPD: begin
                    r_fast  <= r_bres;
                    r_state <= ST_SLOW;
                end
                ST_SLOW: begin
                    if (r_slow == '0) begin
                        r_slow  <= r_rate;
                        r_state <= ST_MRD;
                    end else begin
                        r_bw    <= sat_q16(r_as);
                        r_bx    <= r_rate;
                        r_by    <= r_slow;
                        r_ret   <= ST_SLOW_UPD;
                        r_state <= ST_B1;
                    end
                end
                ST_SLOW_UPD: begin
                    r_slow  <= r_bres;
                    r_state <= ST_MRD;
                end
                ST_MRD: r_state <= ST_MCAP;
                ST_MCAP: begin
                    r_cand  <= r_fb_rd;
                    r_j     <= '0;
                    r_lt    <= '0;
                    r_le    <= '0;
                    r_state <= ST_MSW;
                end
                // rank count of the candidate against every filled slot
                ST_MSW: begin
                    r_lt <= r_lt + HIST_CW'(r_fb_rd < r_cand);
                    r_le <= r_le + HIST_CW'(r_fb_rd <= r_cand);
                    r_j  <= r_j + 1'b1;
                    if (w_j_next == r_count) begin
                        r_state <= ST_MEVAL;
                    end
                end
                ST_MEVAL: begin
                    if (r_lt <= w_phi && r_le > w_phi) begin
                        r_mhi <= r_cand;
                    end
                    if (!r_count[0] && r_lt <= w_plo && r_le > w_plo) begin
                        r_mlo <= r_cand;
                    end
                    r_ci    <= r_ci + 1'b1;
                    r_state <= (r_ci + 1'b1 == r_count) ? ST_MFIN : ST_MRD;
                end
                ST_MFIN: begin
                    r_med   <= r_count[0] ? r_mhi : 32'(({1'b0, r_mlo} + {1'b0, r_mhi}) >> 1);
                    r_state <= ST_HINIT;
                end
                ST_HINIT: begin
                    r_hi   <= '0;
                    r_sum  <= '0;
                    r_kept <= '0;
                    r_p    <= (r_head == '0) ? HIST_IW'(HIST_DEPTH - 1) : r_head - 1'b1;
                    if (w_k == '0) begin
                        r_harm  <= '0;
                        r_state <= ST_EST;
                    end else begin
                        r_state <= ST_HRD;
                    end
                end
                ST_HRD: r_state <= ST_HCHK;
                ST_HCHK: r_state <= (r_rt_rd == '0) ? ST_HNEXT : ST_HWAIT;
                ST_HWAIT: begin
                    if (w_div_rsp.done) begin
                        r_sum   <= r_sum + w_div_rsp.quotient;
                        r_kept  <= r_kept + 1'b1;
                        r_state <= ST_HNEXT;
                    end
                end
                // walk from newest toward oldest
                ST_HNEXT: begin
                    r_hi    <= r_hi + 1'b1;
                    r_p     <= (r_p == '0) ? HIST_IW'(HIST_DEPTH - 1) : r_p - 1'b1;
                    r_state <= (r_hi + 1'b1 == w_k) ? ST_HFIN : ST_HRD;
                end
                ST_HFIN: begin
                    if (r_kept == '0) begin
                        r_harm  <= '0;
                        r_state <= ST_EST;
                    end else begin
                        r_state <= ST_HFWAIT;
                    end
                end
                ST_HFWAIT: begin
                    if (w_div_rsp.done) begin
                        r_harm  <= w_rate_sat;
                        r_state <= ST_EST;
                    end
                end
                ST_EST: begin
                    if (w_m == '0) begin
                        r_thr   <= r_harm;
                        r_state <= ST_POST;
                    end else if (r_harm == '0) begin
                        r_thr   <= w_m;
                        r_state <= ST_POST;
                    end else begin
                        r_bw    <= sat_q16(r_hb);
                        r_bx    <= r_harm;
                        r_by    <= w_m;
                        r_ret   <= ST_EST_UPD;
                        r_state <= ST_B1;
                    end
                end
                ST_EST_UPD: begin
                    r_thr   <= r_bres;
                    r_state <= ST_POST;
                end
                ST_POST: begin
                    if (r_cmd == CMD_RECORD || r_thr == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_PMUL;
                    end
                end
                ST_PMUL: r_state <= ST_PDIV;
                ST_PDIV: r_state <= ST_PWAIT;
                ST_PWAIT: begin
                    if (w_div_rsp.done) begin
                        r_pred  <= sat40({32'd0, r_med} + w_div_rsp.quotient);
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_o_thr  <= r_thr;
                        r_o_med  <= r_med;
                        r_o_pred <= r_pred;
                        r_o_echo <= (r_cmd == CMD_RECORD) ? r_total : 32'd0;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                // shared blend: w*x, then (1-w)*y, then round and scale
                ST_B1: r_state <= ST_B2;
                ST_B2: begin
                    r_acc   <= r_mul;
                    r_state <= ST_B3;
                end
                ST_B3: begin
                    r_bres  <= 40'((r_acc + r_mul + 60'd32768) >> 16);
                    r_state <= r_ret;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid              = r_ovalid;
    assign o_throughput_bps         = r_o_thr;
    assign o_first_byte_estimate_us = r_o_med;
    assign o_predicted_time_us      = r_o_pred;
    assign o_echoed_total_us        = r_o_echo;

    `DTE_ASSERT_NOW(a_idle_div_quiet, i_clk, i_rst_n, r_state == ST_IDLE, !w_div_rsp.busy)
    `DTE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= HIST_CW'(HIST_DEPTH))
    `DTE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule
